>>> design/vlrs_pkg.sv
// Shared constants and types for the vertical line-rate scaler.
// No dependencies; imported by vertical_line_rate_scaler.

package vlrs_pkg;

    // Default build parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_COEFF_BITS = 8;

    // Field widths.
    localparam int PIXEL_W  = 8;
    localparam int LINE_W   = 10;
    localparam int WIDTH_W  = 11;
    localparam int COLUMN_W = 11;
    localparam int PHASE_W  = 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_OUT_PAL   = 2'b00,
        CFG_IN_HEIGHT = 2'b01,
        CFG_IN_WIDTH  = 2'b10
    } cfg_index_t;

    // Register reset values.
    localparam logic [LINE_W-1:0]  RESET_IN_HEIGHT = 10'd480;
    localparam logic [WIDTH_W-1:0] RESET_IN_WIDTH  = 11'd720;

    // Input heights that select the ratio and the output line limit.
    localparam logic [LINE_W-1:0] FIELD_HEIGHT = 10'd288;
    localparam logic [LINE_W-1:0] FRAME_HEIGHT = 10'd480;

    // Output line limits.
    localparam logic [LINE_W-1:0] LIMIT_480 = 10'd480;
    localparam logic [LINE_W-1:0] LIMIT_576 = 10'd576;
    localparam logic [LINE_W-1:0] LIMIT_600 = 10'd600;

    // Largest output byte.
    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'hff;

endpackage

>>> design/vertical_line_rate_scaler.sv
// Vertical line-rate scaler: turns a stream of 4:2:2 bytes into copies and
// blends of the previous and current line. Depends on vlrs_pkg.
//
// Pipeline: an input word is registered in stage one, then in the result holding register.
// Throughput: one input word per cycle when it gives at most one result and
// m_tready is high; the two results of a word take turns on the single result port.
// Reset (aresetn low, synchronous) clears the counters, the pipeline and
// the configuration; the line store is not cleared and is read only after
// it has been written.

module vertical_line_rate_scaler
    import vlrs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int COEFF_BITS = DEF_COEFF_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Configuration write port.
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [WIDTH_W-1:0]  cfg_wdata,

    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] pixel_byte
    input  logic [0:0]          s_tuser,   // [0] start_of_frame

    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [7:0] out_value, [17:8] out_line,
                                           // [28:18] out_column, [31:29] zero
    output logic                m_tlast    // run_last
);

    localparam int LINE_BYTES = 2 * MAX_WIDTH;
    localparam int CW         = $clog2(LINE_BYTES);
    localparam int WE         = WIDTH_W + 1;      // clamped width
    localparam int LB         = WE + 1;           // line length in bytes
    localparam int PW         = COEFF_BITS + 9;
    localparam logic [PW-1:0] HALF = PW'(1) << (COEFF_BITS - 1);
    localparam logic [COEFF_BITS-1:0] C1 =
        COEFF_BITS'(((1 << (COEFF_BITS + 1)) + 5) / 10);
    localparam logic [COEFF_BITS-1:0] C2 =
        COEFF_BITS'(((1 << (COEFF_BITS + 2)) + 5) / 10);

    // Move base toward other by coeff, rounded to nearest with ties away from base, clamped.
    function automatic logic [7:0] blend(input logic [7:0] base,
                                         input logic [7:0] other,
                                         input logic [COEFF_BITS-1:0] coeff);
        logic [7:0]        diff;
        logic [PW-1:0]     prod;
        logic [8:0]        step;
        logic signed [10:0] r;
        diff = (other > base) ? (other - base) : (base - other);
        prod = PW'(diff) * PW'(coeff) + HALF;
        step = prod[COEFF_BITS +: 9];
        if (other > base) begin
            r = $signed({3'b000, base}) + $signed({2'b00, step});
        end else begin
            r = $signed({3'b000, base}) - $signed({2'b00, step});
        end
        if (r > $signed({3'b000, PIXEL_MAX})) begin
            blend = PIXEL_MAX;
        end else if (r < 0) begin
            blend = '0;
        end else begin
            blend = r[7:0];
        end
    endfunction

    // Output byte for phase k out of up steps between prev and cur.
    function automatic logic [7:0] interp(input logic [2:0] k,
                                          input logic [2:0] up,
                                          input logic [7:0] prev,
                                          input logic [7:0] cur);
        logic [3:0] k2;
        logic [8:0] sum;
        k2  = {k, 1'b0};
        sum = {1'b0, prev} + {1'b0, cur} + 9'd1;
        if (k == 3'd0) begin
            interp = prev;
        end else if (k2 < {1'b0, up}) begin
            interp = blend(prev, cur, k[0] ? C1 : C2);
        end else if (k2 == {1'b0, up}) begin
            interp = sum[8:1];
        end else begin
            interp = blend(cur, prev, (up[0] ^ k[0]) ? C1 : C2);
        end
    endfunction

    // Configuration registers.
    logic               out_pal_reg;
    logic [LINE_W-1:0]  in_height_reg;
    logic [WIDTH_W-1:0] in_width_reg;

    // Frame state.
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LINE_W-1:0]  line_cnt_reg, line_cnt_next;
    logic [LINE_W-1:0]  base_reg, base_next;
    logic [CW-1:0]      col_cnt_reg, col_cnt_next;

    // Line store.
    logic [7:0] line_mem [LINE_BYTES];

    // Stage one: accepted word with its stored neighbor.
    logic               s1_valid_reg;
    logic [7:0]         s1_cur_reg;
    logic [7:0]         s1_prev_reg;
    logic [COLUMN_W-1:0] s1_col_reg;
    logic [2:0]         s1_k0_reg, s1_k1_reg, s1_up_reg;
    logic               s1_copy_reg;
    logic [LINE_W-1:0]  s1_line_reg;
    logic [1:0]         s1_n_reg;

    // Result holding register: up to two words.
    logic [7:0]          o_val0_reg, o_val1_reg;
    logic [LINE_W-1:0]   o_line_reg;
    logic [COLUMN_W-1:0] o_col_reg;
    logic [1:0]          o_rem_reg;
    logic                o_head_reg;

    // Front-end decode.
    logic               sof, active, field, first, copy_first, wrap, accept;
    logic [PHASE_W-1:0] phase_eff;
    logic [LINE_W-1:0]  line_eff, base_eff, limit;
    logic [CW-1:0]      cc_eff;
    logic [2:0]         up, down;
    logic [WE-1:0]      width_in, width_eff;
    logic [LB-1:0]      line_bytes, col, col_inc;
    logic [4:0]         k1, k_end, cnt_down;
    logic [1:0]         count, n;
    logic [LINE_W:0]    base_sum, line1;
    logic               e0, e1;

    always_comb begin
        sof       = s_tuser[0];
        accept    = s_tvalid && s_tready;
        line_eff  = sof ? '0 : line_cnt_reg;
        phase_eff = sof ? '0 : phase_reg;
        base_eff  = sof ? '0 : base_reg;
        cc_eff    = sof ? '0 : col_cnt_reg;
        active    = line_eff < in_height_reg;
        field     = in_height_reg == FIELD_HEIGHT;

        // Ratio up/down and output line limit.
        if (field) begin
            up   = out_pal_reg ? 3'd2 : 3'd5;
            down = out_pal_reg ? 3'd1 : 3'd3;
        end else begin
            up   = out_pal_reg ? 3'd5 : 3'd1;
            down = out_pal_reg ? 3'd4 : 3'd1;
        end
        if (!out_pal_reg) begin
            limit = LIMIT_480;
        end else if (in_height_reg == FRAME_HEIGHT) begin
            limit = LIMIT_600;
        end else begin
            limit = LIMIT_576;
        end

        // Clamped line length and current column.
        width_in = {1'b0, in_width_reg};
        if (width_in == '0) begin
            width_eff = WE'(1);
        end else if (width_in > WE'(MAX_WIDTH)) begin
            width_eff = WE'(MAX_WIDTH);
        end else begin
            width_eff = width_in;
        end
        line_bytes = {width_eff, 1'b0};
        col        = (LB'(cc_eff) >= line_bytes) ? '0 : LB'(cc_eff);
        col_inc    = col + LB'(1);
        wrap       = col_inc >= line_bytes;

        // Results this word gives and the phase that the line leaves.
        first      = line_eff == '0;
        copy_first = first && (phase_eff == '0);
        k1         = {2'b00, phase_eff} + {2'b00, down};
        if (copy_first) begin
            count = 2'd1;
        end else if (k1 < {2'b00, up}) begin
            count = 2'd2;
        end else if (phase_eff < up) begin
            count = 2'd1;
        end else begin
            count = 2'd0;
        end
        unique case (count)
            2'd2:    cnt_down = {1'b0, down, 1'b0};
            2'd1:    cnt_down = {2'b00, down};
            default: cnt_down = '0;
        endcase
        k_end = copy_first ? k1
                           : ({2'b00, phase_eff} + cnt_down - {2'b00, up});

        // Output lines below the limit.
        line1 = {1'b0, base_eff} + (LINE_W + 1)'(1);
        e0    = (count != 2'd0) && (base_eff < limit);
        e1    = (count == 2'd2) && (line1 < {1'b0, limit});
        n     = {1'b0, e0} + {1'b0, e1};

        base_sum = {1'b0, base_eff} + (LINE_W + 1)'(count);

        // Next frame state.
        phase_next    = phase_eff;
        line_cnt_next = line_eff;
        base_next     = base_eff;
        col_cnt_next  = cc_eff;
        if (active) begin
            col_cnt_next = wrap ? '0 : col_inc[CW-1:0];
            if (wrap) begin
                line_cnt_next = line_eff + LINE_W'(1);
                phase_next    = k_end[PHASE_W-1:0];
                base_next     = (base_sum > {1'b0, limit}) ? limit
                                                           : base_sum[LINE_W-1:0];
            end
        end
    end

    // Handshake between stages.
    logic out_free, s1_adv, pop;
    always_comb begin
        pop      = m_tvalid && m_tready;
        out_free = (o_rem_reg == 2'd0) || ((o_rem_reg == 2'd1) && m_tready);
        s1_adv   = s1_valid_reg && out_free;
        s_tready = !s1_valid_reg || out_free;
    end

    // Configuration and frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_pal_reg   <= 1'b0;
            in_height_reg <= RESET_IN_HEIGHT;
            in_width_reg  <= RESET_IN_WIDTH;
            phase_reg     <= '0;
            line_cnt_reg  <= '0;
            base_reg      <= '0;
            col_cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_OUT_PAL:   out_pal_reg   <= cfg_wdata[0];
                    CFG_IN_HEIGHT: in_height_reg <= cfg_wdata[LINE_W-1:0];
                    CFG_IN_WIDTH:  in_width_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg    <= phase_next;
                line_cnt_reg <= line_cnt_next;
                base_reg     <= base_next;
                col_cnt_reg  <= col_cnt_next;
            end
        end
    end

    // Line store: read the old byte and write the new one at the same column.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_prev_reg <= line_mem[col[CW-1:0]];
            if (active) begin
                line_mem[col[CW-1:0]] <= s_tdata;
            end
        end
    end

    // Stage one registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= accept && active && (n != 2'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cur_reg  <= s_tdata;
            s1_col_reg  <= col[COLUMN_W-1:0];
            s1_k0_reg   <= phase_eff;
            s1_k1_reg   <= k1[2:0];
            s1_up_reg   <= up;
            s1_copy_reg <= copy_first;
            s1_line_reg <= base_eff;
            s1_n_reg    <= n;
        end
    end

    // Blends for both possible results of the word in stage one.
    logic [7:0] v0, v1;
    always_comb begin
        v0 = s1_copy_reg ? s1_cur_reg
                         : interp(s1_k0_reg, s1_up_reg, s1_prev_reg, s1_cur_reg);
        v1 = interp(s1_k1_reg, s1_up_reg, s1_prev_reg, s1_cur_reg);
    end

    // Result holding register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_rem_reg  <= '0;
            o_head_reg <= 1'b0;
        end else if (s1_adv) begin
            o_rem_reg  <= s1_n_reg;
            o_head_reg <= 1'b0;
        end else if (pop) begin
            o_rem_reg  <= o_rem_reg - 2'd1;
            o_head_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            o_val0_reg <= v0;
            o_val1_reg <= v1;
            o_line_reg <= s1_line_reg;
            o_col_reg  <= s1_col_reg;
        end
    end

    // Result word.
    logic [7:0]        out_value;
    logic [LINE_W-1:0] out_line;
    always_comb begin
        out_value = o_head_reg ? o_val1_reg : o_val0_reg;
        out_line  = o_line_reg + LINE_W'(o_head_reg);
        m_tvalid  = o_rem_reg != 2'd0;
        m_tlast   = o_rem_reg == 2'd1;
        m_tdata   = {3'b000, o_col_reg, out_line, out_value};
    end

endmodule
